>>> src/lru_key_value_cache_top_assert.svh
// Assertion macros for the LRU key/value cache
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define LKV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lkv_pkg.sv
`timescale 1ns / 1ps
package lkv_pkg;
    localparam int ENTRIES  = 16;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int QDEPTH   = 2;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

    typedef struct packed {
        logic                     op;
        logic signed [KEY_W-1:0]  req_key;
        logic signed [DATA_W-1:0] req_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } rsp_t;

    // Front stage output: request plus the clamped capacity at acceptance
    typedef struct packed {
        req_t             req;
        logic [CNT_W-1:0] cap;
    } cmd_t;
endpackage

>>> src/lkv_front.sv
`timescale 1ns / 1ps
module lkv_front
    import lkv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    input  logic [4:0]       cap_raw,
    output logic             q_valid,
    input  logic             q_ready,
    output cmd_t             q_data
);
    cmd_t              buf_reg [QDEPTH];
    logic [0:0]        wptr_reg, rptr_reg;
    logic [1:0]        cnt_reg;
    logic [CNT_W-1:0]  cap_c;
    logic              push, pop;

    // Clamp capacity into 1..ENTRIES
    always_comb begin
        if (cap_raw == 5'd0) begin
            cap_c = CNT_W'(1);
        end else if (32'(cap_raw) > ENTRIES) begin
            cap_c = CNT_W'(ENTRIES);
        end else begin
            cap_c = CNT_W'(cap_raw);
        end
    end

    assign s_ready = (cnt_reg != 2'(QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Command queue
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= '{req: s_data, cap: cap_c};
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> src/lkv_back.sv
`timescale 1ns / 1ps
module lkv_back
    import lkv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    output logic  q_ready,
    input  cmd_t  q_data,
    output logic  m_valid,
    input  logic  m_ready,
    output rsp_t  m_data
);
    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_OUT} state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    keys_reg   [ENTRIES];
    logic [DATA_W-1:0]   vals_reg   [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [SLOT_W-1:0]   rank_reg   [ENTRIES];
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic                free_seen_reg;
    logic [SLOT_W-1:0]   free_slot_reg;
    logic                vic_seen_reg;
    logic [SLOT_W-1:0]   vic_slot_reg;
    logic [SLOT_W-1:0]   vic_rank_reg;
    rsp_t                out_reg;
    logic [SLOT_W-1:0]   si;
    logic [SLOT_W-1:0]   tgt;
    logic                tgt_was_valid;
    logic                do_write;
    logic                do_touch;
    logic [DATA_W-1:0]   rd_val;
    logic                evict_now;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;
    assign si      = idx_reg[SLOT_W-1:0];

    // Decide the slot acted on after the scan
    always_comb begin
        tgt           = found_slot_reg;
        tgt_was_valid = 1'b1;
        do_write      = 1'b0;
        do_touch      = 1'b0;
        if (found_reg) begin
            do_touch = 1'b1;
            do_write = (cmd_reg.req.op == OP_PUT);
        end else if (cmd_reg.req.op == OP_PUT) begin
            if (used_reg < cmd_reg.cap) begin
                tgt           = free_slot_reg;
                tgt_was_valid = 1'b0;
                do_write      = free_seen_reg;
                do_touch      = free_seen_reg;
            end else begin
                tgt      = vic_slot_reg;
                do_write = vic_seen_reg;
                do_touch = vic_seen_reg;
            end
        end
    end

    // Result fields: value read on get, eviction on a put that replaces
    always_comb begin
        rd_val    = '0;
        evict_now = 1'b0;
        if (cmd_reg.req.op == OP_GET) begin
            rd_val = found_reg ? vals_reg[found_slot_reg] : '1;
        end else begin
            evict_now = !found_reg && used_reg >= cmd_reg.cap && vic_seen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg       <= q_data;
                        idx_reg       <= '0;
                        found_reg     <= 1'b0;
                        free_seen_reg <= 1'b0;
                        vic_seen_reg  <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                // One slot per cycle: match, first free, oldest valid
                ST_SCAN: begin
                    if (valid_reg[si]) begin
                        if (!found_reg && keys_reg[si] == cmd_reg.req.req_key) begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= si;
                        end
                        if (!vic_seen_reg || rank_reg[si] > vic_rank_reg) begin
                            vic_seen_reg <= 1'b1;
                            vic_slot_reg <= si;
                            vic_rank_reg <= rank_reg[si];
                        end
                    end else if (!free_seen_reg) begin
                        free_seen_reg <= 1'b1;
                        free_slot_reg <= si;
                    end
                    if (idx_reg == CNT_W'(ENTRIES - 1)) begin
                        state_reg <= ST_UPDATE;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                // Apply write and recency update, build result
                ST_UPDATE: begin
                    out_reg.hit         <= found_reg;
                    out_reg.read_value  <= rd_val;
                    out_reg.evicted     <= evict_now;
                    out_reg.evicted_key <= evict_now ? keys_reg[vic_slot_reg] : '0;
                    if (do_write) begin
                        keys_reg[tgt] <= cmd_reg.req.req_key;
                        vals_reg[tgt] <= cmd_reg.req.req_value;
                    end
                    if (do_touch) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (SLOT_W'(i) != tgt && valid_reg[i] &&
                                (!tgt_was_valid || rank_reg[i] < rank_reg[tgt])) begin
                                rank_reg[i] <= rank_reg[i] + 1'b1;
                            end
                        end
                        rank_reg[tgt]  <= '0;
                        valid_reg[tgt] <= 1'b1;
                        if (!tgt_was_valid) used_reg <= used_reg + 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> src/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// LRU key/value cache, fully associative, 16 entries.
// Input channel s_*: one request (op get/put, key, value) per transfer.
// Result channel m_*: exactly one result per request, in request order.
// APB port: register 0 (capacity_in_use, 5 bits) at byte address 0; write
// only while idle. Capacity 0 acts as 1, above 16 acts as 16.
// A two-entry command queue takes requests while the engine is busy.
// The engine scans the 16 slots one per cycle (match, first free slot,
// oldest entry), then applies the write and recency update in the update state.
// The result is held in an output register until m_ready is high; the
// engine does not start the next request meanwhile, but the queue still
// accepts up to two more requests.
// Reset (aresetn low, synchronous) empties the cache and queue and sets
// capacity to 16. Key and value storage is not cleared.
module lru_key_value_cache_top
    import lkv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "lru_key_value_cache_top_assert.svh"

    logic [4:0] cap_reg;
    logic       q_valid, q_ready;
    cmd_t       q_data;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY) ? {27'd0, cap_reg} : 32'd0;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 5'd16;
        end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
            cap_reg <= pwdata[4:0];
        end
    end

    lkv_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .cap_raw(cap_reg), .q_valid, .q_ready, .q_data
    );

    lkv_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );

    `LKV_ASSERT_IMPL(a_no_evict_key, aclk, aresetn,
        m_valid && !m_data.evicted, m_data.evicted_key == 0, "key reported without eviction")
    `LKV_ASSERT_IMPL(a_evict_no_hit, aclk, aresetn,
        m_valid && m_data.evicted, !m_data.hit && m_data.read_value == 0, "evict with hit")
    `LKV_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `LKV_ASSERT_IMPL(a_hit_no_evict, aclk, aresetn,
        m_valid && m_data.hit, !m_data.evicted && m_data.evicted_key == 0, "hit evicted")
endmodule
